// ----- rtl/jtke_pkg.sv -----
`default_nettype none

package jtke_pkg;

    localparam int KEY_BYTES  = 32;
    localparam int HOLD_DEPTH = 15;

    localparam int KEY_LEN_W  = 6;
    localparam int KEY_IDX_W  = $clog2(KEY_BYTES);
    localparam int KEY_REGS   = KEY_BYTES / 8;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 64;
    localparam int HOLD_CNT_W = $clog2(HOLD_DEPTH + 1);
    localparam int HOLD_IDX_W = (HOLD_DEPTH > 1) ? $clog2(HOLD_DEPTH) : 1;
    localparam int DEPTH_W    = 16;
    localparam int STR_CNT_W  = 6;

    localparam logic [CFG_ADDR_W-1:0] CFG_KEY_LEN   = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_KEY_FIRST = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_KEY_LAST  = 3'd4;

    localparam logic [7:0] CH_COLON  = 8'h3a;
    localparam logic [7:0] CH_LBRACE = 8'h7b;
    localparam logic [7:0] CH_RBRACE = 8'h7d;
    localparam logic [7:0] CH_LBRACK = 8'h5b;
    localparam logic [7:0] CH_RBRACK = 8'h5d;
    localparam logic [7:0] CH_COMMA  = 8'h2c;
    localparam logic [7:0] CH_BSLASH = 8'h5c;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_CR     = 8'h0d;

    typedef logic signed [DEPTH_W-1:0] t_depth;
    typedef logic [KEY_BYTES-1:0][7:0] t_key;

    typedef enum logic [7:0] {
        M_SEARCH    = 8'b0000_0001,
        M_KEYSTR    = 8'b0000_0010,
        M_AFTERKEY  = 8'b0000_0100,
        M_BEFOREVAL = 8'b0000_1000,
        M_VALSTR    = 8'b0001_0000,
        M_VALNEST   = 8'b0010_0000,
        M_VALPRIM   = 8'b0100_0000,
        M_DONE      = 8'b1000_0000
    } t_mode;

    localparam t_depth DEPTH_MAX = {1'b0, {(DEPTH_W-1){1'b1}}};
    localparam t_depth DEPTH_MIN = {1'b1, {(DEPTH_W-1){1'b0}}};

    function automatic t_depth sat_inc(input t_depth v);
        return (v == DEPTH_MAX) ? v : t_depth'(v + t_depth'(1));
    endfunction

    function automatic t_depth sat_dec(input t_depth v);
        return (v == DEPTH_MIN) ? v : t_depth'(v - t_depth'(1));
    endfunction

    function automatic logic is_ws(input logic [7:0] b);
        return (b == CH_SPACE) || (b >= CH_TAB && b <= CH_CR);
    endfunction

endpackage

`default_nettype wire

// ----- rtl/json_top_level_key_extractor.sv -----
// JSON top-level key extractor.
// Document bytes enter on the s_axis request channel, one byte per request,
// tlast marking the final byte. Each byte is scanned in the cycle it is
// accepted; results leave the m_axis output register one per cycle while the
// receiver takes them, a byte's first in the cycle after it. Value bytes carry
// tuser[0]; the request closing a document carries tuser[1] with key_found and
// hold_overflowed, and tlast closes the results of each input byte.
// Throughput is one byte per cycle while the receiver keeps up. A byte that
// releases held whitespace inside a primitive value stalls input while the
// hold store is drained in order, then the byte itself follows. Outside a
// drain, input is accepted whenever the output register is empty or being
// taken, so a stalled receiver stalls the input after one buffered result.
// Configuration writes (key length, key bytes) take effect on the next edge
// and must only be issued while the block is idle.
// Synchronous reset clears the scan state and the key registers; after each
// verdict the scan state returns to its reset value for the next document.
`default_nettype none

module json_top_level_key_extractor
    import jtke_pkg::*;
(
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_cfg_we,
    input  wire [CFG_ADDR_W-1:0]  i_cfg_addr,
    input  wire [CFG_DATA_W-1:0]  i_cfg_data,
    input  wire                   i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    input  wire [7:0]             i_s_axis_tdata,   // [7:0] doc_byte
    input  wire                   i_s_axis_tlast,   // doc_end
    output logic                  o_m_axis_tvalid,
    input  wire                   i_m_axis_tready,
    output logic [15:0]           o_m_axis_tdata,   // [7:0] value_byte, [8] key_found,
                                                    // [9] hold_overflowed, [15:10] zero
    output logic [1:0]            o_m_axis_tuser,   // [0] value_valid, [1] verdict_valid
    output logic                  o_m_axis_tlast    // run_last
);

    logic [KEY_LEN_W-1:0]         r_key_len;
    logic [KEY_REGS-1:0][63:0]    r_key;
    t_key                         key_view;
    logic [KEY_LEN_W-1:0]         klen;

    t_mode                        r_mode, n_mode;
    t_depth                       r_obj, n_obj, r_arr, n_arr;
    t_depth                       r_vobj, n_vobj, r_varr, n_varr;
    logic                         r_esc, n_esc, r_vin, n_vin, r_match, n_match;
    logic [STR_CNT_W-1:0]         r_cnt, n_cnt;
    logic [HOLD_CNT_W-1:0]        r_hcnt, n_hcnt;
    logic                         r_ovf, n_ovf;
    logic [7:0]                   r_hold [HOLD_DEPTH];

    logic                         r_flush, n_flush;
    logic [HOLD_CNT_W-1:0]        r_fidx, n_fidx;
    logic [7:0]                   r_pend_byte, n_pend_byte;
    logic                         r_pend_end, n_pend_end;

    logic                         r_ov, n_ov;
    logic [7:0]                   r_o_byte, n_o_byte;
    logic                         r_o_vvalid, n_o_vvalid, r_o_verdict, n_o_verdict;
    logic                         r_o_found, n_o_found, r_o_ovf, n_o_ovf;
    logic                         r_o_last, n_o_last;

    logic                         advance, in_acc;
    logic [7:0]                   b;
    logic                         e;
    t_depth                       srch_obj, srch_arr, nv_obj, nv_arr;
    t_mode                        srch_mode;
    logic                         srch_quote;
    logic                         kc_fail;
    logic [STR_CNT_W-1:0]         kc_cnt;
    logic                         emit, flush_go, do_reset, hold_we;
    logic                         is_term;

    assign key_view = r_key;
    assign klen     = (r_key_len > KEY_LEN_W'(KEY_BYTES)) ? KEY_LEN_W'(KEY_BYTES) : r_key_len;

    assign advance         = !r_ov || i_m_axis_tready;
    assign o_s_axis_tready = advance && !r_flush;
    assign in_acc          = i_s_axis_tvalid && o_s_axis_tready;
    assign b               = i_s_axis_tdata;
    assign e               = i_s_axis_tlast;

    assign srch_quote = (b == CH_QUOTE);
    assign srch_mode  = srch_quote ? M_KEYSTR : M_SEARCH;
    assign srch_obj   = (b == CH_LBRACE) ? sat_inc(r_obj) :
                        (b == CH_RBRACE) ? sat_dec(r_obj) : r_obj;
    assign srch_arr   = (b == CH_LBRACK) ? sat_inc(r_arr) :
                        (b == CH_RBRACK) ? sat_dec(r_arr) : r_arr;

    assign kc_fail = (r_cnt >= klen) || (b != key_view[r_cnt[KEY_IDX_W-1:0]]);
    assign kc_cnt  = (r_cnt == {STR_CNT_W{1'b1}}) ? r_cnt : r_cnt + STR_CNT_W'(1);

    assign nv_obj  = (b == CH_LBRACE) ? sat_inc(r_vobj) :
                     (b == CH_RBRACE) ? sat_dec(r_vobj) : r_vobj;
    assign nv_arr  = (b == CH_LBRACK) ? sat_inc(r_varr) :
                     (b == CH_RBRACK) ? sat_dec(r_varr) : r_varr;

    assign is_term = (b == CH_COMMA) || (b == CH_RBRACE) || (b == CH_RBRACK);

    always_comb begin
        n_mode      = r_mode;
        n_obj       = r_obj;
        n_arr       = r_arr;
        n_vobj      = r_vobj;
        n_varr      = r_varr;
        n_esc       = r_esc;
        n_vin       = r_vin;
        n_match     = r_match;
        n_cnt       = r_cnt;
        n_hcnt      = r_hcnt;
        n_ovf       = r_ovf;
        n_flush     = r_flush;
        n_fidx      = r_fidx;
        n_pend_byte = r_pend_byte;
        n_pend_end  = r_pend_end;
        n_ov        = r_ov;
        n_o_byte    = r_o_byte;
        n_o_vvalid  = r_o_vvalid;
        n_o_verdict = r_o_verdict;
        n_o_found   = r_o_found;
        n_o_ovf     = r_o_ovf;
        n_o_last    = r_o_last;
        emit        = 1'b0;
        flush_go    = 1'b0;
        do_reset    = 1'b0;
        hold_we     = 1'b0;

        if (in_acc) begin
            unique case (r_mode)
                M_SEARCH: begin
                    n_mode = srch_mode;
                    n_obj  = srch_obj;
                    n_arr  = srch_arr;
                    if (srch_quote) begin
                        n_cnt   = '0;
                        n_match = 1'b1;
                        n_esc   = 1'b0;
                    end
                end
                M_KEYSTR: begin
                    if (!r_esc && b == CH_QUOTE) begin
                        if (r_match && r_cnt == klen && r_obj == t_depth'(1) &&
                            r_arr == t_depth'(0)) begin
                            n_mode = M_AFTERKEY;
                        end else begin
                            n_mode = M_SEARCH;
                        end
                    end else begin
                        n_esc   = !r_esc && (b == CH_BSLASH);
                        n_match = r_match && !kc_fail;
                        n_cnt   = kc_cnt;
                    end
                end
                M_AFTERKEY: begin
                    if (is_ws(b)) begin
                        n_mode = r_mode;
                    end else if (b == CH_COLON) begin
                        n_mode = M_BEFOREVAL;
                    end else begin
                        n_mode = srch_mode;
                        n_obj  = srch_obj;
                        n_arr  = srch_arr;
                        if (srch_quote) begin
                            n_cnt   = '0;
                            n_match = 1'b1;
                            n_esc   = 1'b0;
                        end
                    end
                end
                M_BEFOREVAL: begin
                    if (is_ws(b)) begin
                        n_mode = r_mode;
                    end else if (b == CH_QUOTE) begin
                        emit   = 1'b1;
                        n_esc  = 1'b0;
                        n_mode = M_VALSTR;
                    end else if (b == CH_LBRACE || b == CH_LBRACK) begin
                        emit   = 1'b1;
                        n_vobj = (b == CH_LBRACE) ? t_depth'(1) : t_depth'(0);
                        n_varr = (b == CH_LBRACK) ? t_depth'(1) : t_depth'(0);
                        n_vin  = 1'b0;
                        n_esc  = 1'b0;
                        n_mode = M_VALNEST;
                    end else if (is_term) begin
                        n_hcnt = '0;
                        n_mode = M_DONE;
                    end else begin
                        emit   = 1'b1;
                        n_hcnt = '0;
                        n_mode = M_VALPRIM;
                    end
                end
                M_VALSTR: begin
                    emit  = 1'b1;
                    n_esc = !r_esc && (b == CH_BSLASH);
                    if (!r_esc && b == CH_QUOTE) begin
                        n_mode = M_DONE;
                    end
                end
                M_VALNEST: begin
                    emit = 1'b1;
                    if (r_vin) begin
                        n_esc = !r_esc && (b == CH_BSLASH);
                        if (!r_esc && b == CH_QUOTE) begin
                            n_vin = 1'b0;
                        end
                    end else begin
                        n_vin  = (b == CH_QUOTE);
                        n_vobj = nv_obj;
                        n_varr = nv_arr;
                        if (nv_obj == t_depth'(0) && nv_arr == t_depth'(0)) begin
                            n_mode = M_DONE;
                        end
                    end
                end
                M_VALPRIM: begin
                    if (is_term) begin
                        n_hcnt = '0;
                        n_mode = M_DONE;
                    end else if (is_ws(b)) begin
                        if (r_hcnt < HOLD_CNT_W'(HOLD_DEPTH)) begin
                            hold_we = 1'b1;
                            n_hcnt  = r_hcnt + HOLD_CNT_W'(1);
                        end else begin
                            n_ovf = 1'b1;
                        end
                    end else if (r_hcnt == '0) begin
                        emit = 1'b1;
                    end else begin
                        flush_go = 1'b1;
                    end
                end
                M_DONE: begin
                    n_mode = r_mode;
                end
                default: begin
                    n_mode = M_SEARCH;
                end
            endcase

            if (flush_go) begin
                n_flush     = 1'b1;
                n_fidx      = HOLD_CNT_W'(1);
                n_pend_byte = b;
                n_pend_end  = e;
                n_ov        = 1'b1;
                n_o_byte    = r_hold[0];
                n_o_vvalid  = 1'b1;
                n_o_verdict = 1'b0;
                n_o_found   = 1'b0;
                n_o_ovf     = 1'b0;
                n_o_last    = 1'b0;
            end else if (e) begin
                n_ov        = 1'b1;
                n_o_byte    = emit ? b : 8'h00;
                n_o_vvalid  = emit;
                n_o_verdict = 1'b1;
                n_o_found   = (n_mode == M_DONE) || (n_mode == M_VALPRIM);
                n_o_ovf     = n_ovf;
                n_o_last    = 1'b1;
                do_reset    = 1'b1;
            end else begin
                n_ov        = emit;
                n_o_byte    = b;
                n_o_vvalid  = 1'b1;
                n_o_verdict = 1'b0;
                n_o_found   = 1'b0;
                n_o_ovf     = 1'b0;
                n_o_last    = 1'b1;
            end
        end else if (r_flush && advance) begin
            n_ov        = 1'b1;
            n_o_vvalid  = 1'b1;
            if (r_fidx < r_hcnt) begin
                n_o_byte    = r_hold[r_fidx[HOLD_IDX_W-1:0]];
                n_o_verdict = 1'b0;
                n_o_found   = 1'b0;
                n_o_ovf     = 1'b0;
                n_o_last    = 1'b0;
                n_fidx      = r_fidx + HOLD_CNT_W'(1);
            end else begin
                n_o_byte    = r_pend_byte;
                n_o_verdict = r_pend_end;
                n_o_found   = r_pend_end;
                n_o_ovf     = r_pend_end && r_ovf;
                n_o_last    = 1'b1;
                n_hcnt      = '0;
                n_flush     = 1'b0;
                do_reset    = r_pend_end;
            end
        end else if (advance) begin
            n_ov = 1'b0;
        end

        if (do_reset) begin
            n_mode  = M_SEARCH;
            n_obj   = '0;
            n_arr   = '0;
            n_vobj  = '0;
            n_varr  = '0;
            n_esc   = 1'b0;
            n_vin   = 1'b0;
            n_match = 1'b1;
            n_cnt   = '0;
            n_hcnt  = '0;
            n_ovf   = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_len <= '0;
            r_key     <= '0;
            r_mode    <= M_SEARCH;
            r_obj     <= '0;
            r_arr     <= '0;
            r_vobj    <= '0;
            r_varr    <= '0;
            r_esc     <= 1'b0;
            r_vin     <= 1'b0;
            r_match   <= 1'b1;
            r_cnt     <= '0;
            r_hcnt    <= '0;
            r_ovf     <= 1'b0;
            r_flush   <= 1'b0;
            r_fidx    <= '0;
            r_ov      <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_addr == CFG_KEY_LEN) begin
                    r_key_len <= i_cfg_data[KEY_LEN_W-1:0];
                end else if (i_cfg_addr >= CFG_KEY_FIRST && i_cfg_addr <= CFG_KEY_LAST) begin
                    r_key[2'(i_cfg_addr - CFG_KEY_FIRST)] <= i_cfg_data;
                end
            end
            r_mode  <= n_mode;
            r_obj   <= n_obj;
            r_arr   <= n_arr;
            r_vobj  <= n_vobj;
            r_varr  <= n_varr;
            r_esc   <= n_esc;
            r_vin   <= n_vin;
            r_match <= n_match;
            r_cnt   <= n_cnt;
            r_hcnt  <= n_hcnt;
            r_ovf   <= n_ovf;
            r_flush <= n_flush;
            r_fidx  <= n_fidx;
            r_ov    <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        if (hold_we) begin
            r_hold[r_hcnt[HOLD_IDX_W-1:0]] <= b;
        end
        r_pend_byte <= n_pend_byte;
        r_pend_end  <= n_pend_end;
        r_o_byte    <= n_o_byte;
        r_o_vvalid  <= n_o_vvalid;
        r_o_verdict <= n_o_verdict;
        r_o_found   <= n_o_found;
        r_o_ovf     <= n_o_ovf;
        r_o_last    <= n_o_last;
    end

    assign o_m_axis_tvalid = r_ov;
    assign o_m_axis_tdata  = {6'b0, r_o_ovf, r_o_found, r_o_byte};
    assign o_m_axis_tuser  = {r_o_verdict, r_o_vvalid};
    assign o_m_axis_tlast  = r_o_last;

endmodule

`default_nettype wire
